// ----- hdl/hrbd_pkg.sv -----
// Shared types, codes and character tables for the HTTP response body deframer.
package hrbd_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
  localparam logic [1:0] FUNC_CLOSE   = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;

  // Framing codes reported on the output.
  localparam logic [1:0] FRAMING_NONE    = 2'd0;
  localparam logic [1:0] FRAMING_LENGTH  = 2'd1;
  localparam logic [1:0] FRAMING_CHUNKED = 2'd2;

  // Characters used by the parsers.
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Header line patterns; each begins with the newline that opens the line.
  localparam int unsigned LEN_PAT = 17;
  localparam int unsigned CHK_PAT = 27;
  localparam logic [LEN_PAT*8-1:0] PAT_LEN_CAP = "\nContent-Length: ";
  localparam logic [LEN_PAT*8-1:0] PAT_LEN_LOW = "\ncontent-length: ";
  localparam logic [CHK_PAT*8-1:0] PAT_CHK_CAP = "\nTransfer-Encoding: chunked";
  localparam logic [CHK_PAT*8-1:0] PAT_CHK_LOW = "\ntransfer-encoding: chunked";

  // Status line parse steps.
  localparam logic [1:0] ST_WAIT_SPACE = 2'd0;
  localparam logic [1:0] ST_SKIP_BLANK = 2'd1;
  localparam logic [1:0] ST_DIGITS     = 2'd2;
  localparam logic [1:0] ST_FINISHED   = 2'd3;

  localparam logic [9:0] STATUS_MAX = 10'd999;

  // What the header tracker tells the body sequencer about the current byte.
  typedef struct packed {
    logic       hdr_end;
    logic       length_seen;
    logic       chunked_seen;
    logic [9:0] status_value;
  } hdr_info_t;

  // Flags of one result item from the body sequencer.
  typedef struct packed {
    logic body_valid;
    logic header_done;
    logic response_done;
  } body_flags_t;

  // Byte of pattern k at position pos; pos must be below that pattern's length.
  function automatic logic [7:0] pat_byte(input logic [1:0] k, input logic [4:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (k)
      2'd0: b = PAT_LEN_CAP[(5'(LEN_PAT - 1) - pos) * 8 +: 8];
      2'd1: b = PAT_LEN_LOW[(5'(LEN_PAT - 1) - pos) * 8 +: 8];
      2'd2: b = PAT_CHK_CAP[(5'(CHK_PAT - 1) - pos) * 8 +: 8];
      2'd3: b = PAT_CHK_LOW[(5'(CHK_PAT - 1) - pos) * 8 +: 8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Hex digit value; ok is low for a byte that is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    logic       ok;
    v  = 4'd0;
    ok = 1'b1;
    if (b >= "0" && b <= "9") begin
      v = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      v = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      v = 4'(b - "A" + 8'd10);
    end else begin
      ok = 1'b0;
    end
    return {ok, v};
  endfunction

endpackage

// ----- hdl/http_response_body_deframer.sv -----
// Top level of the HTTP response body deframer with its input and result registers.
//
// Takes one received HTTP response byte (or a close or start event) per transfer and
// returns exactly one result per item. An item is first held in the input register,
// where the header-match and body-sequencer logic works on it, and its result is then
// held in the result register, from which it is offered; one item can be taken every
// cycle while the result register is not stalled. The input side stalls only while
// the input register is full and the result register holds a result that is not
// taken in that cycle. COUNT_WIDTH (16 to 64) sets the width of the content length
// and chunk size counters, which saturate at all ones.
module http_response_body_deframer #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // body_byte[7:0], header_done[8], status_code[18:9], framing[20:19], zero fill[23:21]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // body_valid[0]
  output logic        m_axis_tlast    // response_done
);

  logic                   in_valid;
  logic [1:0]             in_func;
  logic [7:0]             in_byte;
  logic                   advance;
  logic                   hdr_step, hdr_clear;
  logic                   in_header;
  hrbd_pkg::hdr_info_t    info;
  hrbd_pkg::body_flags_t  flags;
  logic [COUNT_WIDTH-1:0] length_value;
  logic [1:0]             framing;

  // An item moves to the result register when that register is free or being emptied.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  assign hdr_step  = advance && (in_func == hrbd_pkg::FUNC_RX_BYTE) && in_header;
  assign hdr_clear = advance && (in_func == hrbd_pkg::FUNC_START);

  hrbd_hdr #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hdr (
    .clk          (clk),
    .rst          (rst),
    .step         (hdr_step),
    .clear        (hdr_clear),
    .data_byte    (in_byte),
    .info         (info),
    .length_value (length_value)
  );

  hrbd_body #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_body (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .func         (in_func),
    .data_byte    (in_byte),
    .info         (info),
    .length_value (length_value),
    .in_header    (in_header),
    .flags        (flags)
  );

  assign framing = info.chunked_seen ? hrbd_pkg::FRAMING_CHUNKED
                 : (info.length_seen ? hrbd_pkg::FRAMING_LENGTH : hrbd_pkg::FRAMING_NONE);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {3'b000, framing, info.status_value, flags.header_done,
                       flags.body_valid ? in_byte : 8'h00};
      m_axis_tuser <= flags.body_valid;
      m_axis_tlast <= flags.response_done;
    end
  end

endmodule

// ----- hdl/hrbd_hdr.sv -----
// Header tracker: blank line detection, status code and framing header match.
module hrbd_hdr #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   clear,
  input  logic [7:0]             data_byte,
  output hrbd_pkg::hdr_info_t    info,
  output logic [COUNT_WIDTH-1:0] length_value
);

  logic [1:0]             blank_line_progress, blank_line_progress_next;
  logic [4:0]             pattern_position, pattern_position_next;
  logic [3:0]             patterns_alive, patterns_alive_next;
  logic [1:0]             status_parse_step, status_parse_step_next;
  logic [9:0]             status_value, status_value_next;
  logic                   length_seen, length_seen_next;
  logic                   chunked_seen, chunked_seen_next;
  logic [COUNT_WIDTH-1:0] length_reg, length_next;

  logic [COUNT_WIDTH+3:0] len_wide;
  logic [13:0]            status_wide;
  logic [3:0]             match;
  logic [4:0]             pos_inc;
  logic [7:0]             blank_char;
  logic                   blank_end;
  logic                   is_dig;
  logic [3:0]             dig;

  assign is_dig = hrbd_pkg::is_digit(data_byte);
  assign dig    = data_byte[3:0];

  // Decimal accumulate of the length, saturating at all ones.
  assign len_wide = ({4'b0, length_reg} << 3) + ({4'b0, length_reg} << 1)
                  + (COUNT_WIDTH+4)'(dig);

  assign status_wide = ({4'b0, status_value} << 3) + ({4'b0, status_value} << 1)
                     + 14'(dig);

  assign pos_inc = pattern_position + 5'd1;

  // Per-pattern compare at the current position.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      match[k] = patterns_alive[k]
               && (pattern_position < ((k < 2) ? 5'(hrbd_pkg::LEN_PAT)
                                               : 5'(hrbd_pkg::CHK_PAT)))
               && (hrbd_pkg::pat_byte(2'(k), pattern_position) == data_byte);
    end
  end

  // Blank line progress: CR LF CR LF.
  always_comb begin
    blank_char = blank_line_progress[0] ? hrbd_pkg::CH_LF : hrbd_pkg::CH_CR;
    blank_end  = 1'b0;
    if (data_byte == blank_char) begin
      blank_line_progress_next = blank_line_progress + 2'd1;
      blank_end = (blank_line_progress == 2'd3);
    end else begin
      blank_line_progress_next = (data_byte == hrbd_pkg::CH_CR) ? 2'd1 : 2'd0;
    end
  end

  // Framing header match and length digits.
  always_comb begin
    pattern_position_next = pattern_position;
    patterns_alive_next   = patterns_alive;
    length_seen_next      = length_seen;
    chunked_seen_next     = chunked_seen;
    length_next           = length_reg;
    if (data_byte == hrbd_pkg::CH_LF) begin
      pattern_position_next = 5'd1;
      patterns_alive_next   = 4'hf;
    end else if (pattern_position == 5'd0) begin
      pattern_position_next = 5'd0;
    end else if (pattern_position >= 5'(hrbd_pkg::LEN_PAT) && (patterns_alive[1:0] != 2'b00))
    begin
      if (pattern_position == 5'(hrbd_pkg::LEN_PAT)
          && (data_byte == hrbd_pkg::CH_SPACE || data_byte == hrbd_pkg::CH_TAB)) begin
        pattern_position_next = pattern_position;
      end else if (is_dig) begin
        length_next = (len_wide[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0)
                    ? {COUNT_WIDTH{1'b1}} : len_wide[COUNT_WIDTH-1:0];
        pattern_position_next = 5'(hrbd_pkg::LEN_PAT + 1);
      end else begin
        pattern_position_next = 5'd0;
        patterns_alive_next   = 4'h0;
      end
    end else begin
      pattern_position_next = pos_inc;
      patterns_alive_next   = match;
      if (match == 4'h0) begin
        pattern_position_next = 5'd0;
      end else if (pos_inc == 5'(hrbd_pkg::LEN_PAT) && (match[1:0] != 2'b00)) begin
        if (!length_seen && !chunked_seen) begin
          length_seen_next = 1'b1;
          length_next      = '0;
        end else begin
          pattern_position_next = 5'd0;
          patterns_alive_next   = 4'h0;
        end
      end else if (pos_inc == 5'(hrbd_pkg::CHK_PAT) && (match[3:2] != 2'b00)) begin
        if (!length_seen && !chunked_seen) begin
          chunked_seen_next = 1'b1;
        end
        pattern_position_next = 5'd0;
        patterns_alive_next   = 4'h0;
      end
    end
    // The end of the header drops any match in progress.
    if (blank_end) begin
      pattern_position_next = 5'd0;
      patterns_alive_next   = 4'h0;
    end
  end

  // Status code after the first space.
  always_comb begin
    status_parse_step_next = status_parse_step;
    status_value_next      = status_value;
    unique case (status_parse_step)
      hrbd_pkg::ST_WAIT_SPACE: begin
        if (data_byte == hrbd_pkg::CH_SPACE) begin
          status_parse_step_next = hrbd_pkg::ST_SKIP_BLANK;
        end
      end
      hrbd_pkg::ST_SKIP_BLANK: begin
        if (is_dig) begin
          status_value_next      = 10'(dig);
          status_parse_step_next = hrbd_pkg::ST_DIGITS;
        end else if (data_byte != hrbd_pkg::CH_SPACE && data_byte != hrbd_pkg::CH_TAB) begin
          status_parse_step_next = hrbd_pkg::ST_FINISHED;
        end
      end
      hrbd_pkg::ST_DIGITS: begin
        if (is_dig) begin
          status_value_next = (status_wide > 14'(hrbd_pkg::STATUS_MAX))
                            ? hrbd_pkg::STATUS_MAX : status_wide[9:0];
        end else begin
          status_parse_step_next = hrbd_pkg::ST_FINISHED;
        end
      end
      default: status_parse_step_next = status_parse_step;
    endcase
  end

  // Header state registers.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      blank_line_progress <= 2'd0;
      pattern_position    <= 5'd0;
      patterns_alive      <= 4'h0;
      status_parse_step   <= hrbd_pkg::ST_WAIT_SPACE;
      status_value        <= 10'd0;
      length_seen         <= 1'b0;
      chunked_seen        <= 1'b0;
      length_reg          <= '0;
    end else if (step) begin
      blank_line_progress <= blank_line_progress_next;
      pattern_position    <= pattern_position_next;
      patterns_alive      <= patterns_alive_next;
      status_parse_step   <= status_parse_step_next;
      status_value        <= status_value_next;
      length_seen         <= length_seen_next;
      chunked_seen        <= chunked_seen_next;
      length_reg          <= length_next;
    end
  end

  // Values as they stand after the current byte; a blank line end never changes them.
  always_comb begin
    info.hdr_end      = step && blank_end;
    info.length_seen  = step ? length_seen_next : length_seen;
    info.chunked_seen = step ? chunked_seen_next : chunked_seen;
    info.status_value = step ? status_value_next : status_value;
    info.status_value = clear ? 10'd0 : info.status_value;
    info.length_seen  = clear ? 1'b0 : info.length_seen;
    info.chunked_seen = clear ? 1'b0 : info.chunked_seen;
  end

  assign length_value = length_reg;

endmodule

// ----- hdl/hrbd_body.sv -----
// Body sequencer: phase of the response, length countdown and chunk size decode.
module hrbd_body #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [1:0]               func,
  input  logic [7:0]               data_byte,
  input  hrbd_pkg::hdr_info_t      info,
  input  logic [COUNT_WIDTH-1:0]   length_value,
  output logic                     in_header,
  output hrbd_pkg::body_flags_t    flags
);

  localparam logic [2:0] PH_HEADER     = 3'd0;
  localparam logic [2:0] PH_LENGTH     = 3'd1;
  localparam logic [2:0] PH_CSIZE      = 3'd2;
  localparam logic [2:0] PH_CDATA      = 3'd3;
  localparam logic [2:0] PH_CEND       = 3'd4;
  localparam logic [2:0] PH_UNFRAMED   = 3'd5;
  localparam logic [2:0] PH_DONE       = 3'd6;
  localparam logic [2:0] PH_CLOSED_HDR = 3'd7;

  logic [2:0]             phase, phase_next;
  logic [COUNT_WIDTH-1:0] bytes_remaining, bytes_remaining_next;
  logic                   size_digits_ended, size_digits_ended_next;
  logic [COUNT_WIDTH-1:0] remaining_dec;
  logic [COUNT_WIDTH+3:0] size_wide;
  logic [4:0]             hex;
  logic                   valid, done;

  assign in_header = (phase == PH_HEADER);

  assign remaining_dec = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;
  assign hex           = hrbd_pkg::hex_val(data_byte);
  assign size_wide     = {bytes_remaining, hex[3:0]};

  // Phase transitions for one item; the spare code changes nothing.
  always_comb begin
    phase_next             = phase;
    bytes_remaining_next   = bytes_remaining;
    size_digits_ended_next = size_digits_ended;
    valid                  = 1'b0;
    done                   = 1'b0;
    if (func == hrbd_pkg::FUNC_START) begin
      phase_next             = PH_HEADER;
      bytes_remaining_next   = '0;
      size_digits_ended_next = 1'b0;
    end else if (func == hrbd_pkg::FUNC_CLOSE) begin
      if (phase == PH_HEADER) begin
        phase_next = PH_CLOSED_HDR;
        done       = 1'b1;
      end else if (phase != PH_DONE && phase != PH_CLOSED_HDR) begin
        phase_next = PH_DONE;
        done       = 1'b1;
      end
    end else if (func == hrbd_pkg::FUNC_RX_BYTE) begin
      unique case (phase)
        PH_HEADER: begin
          if (info.hdr_end) begin
            if (info.chunked_seen) begin
              phase_next             = PH_CSIZE;
              bytes_remaining_next   = '0;
              size_digits_ended_next = 1'b0;
            end else if (info.length_seen) begin
              bytes_remaining_next = length_value;
              if (length_value == '0) begin
                phase_next = PH_DONE;
                done       = 1'b1;
              end else begin
                phase_next = PH_LENGTH;
              end
            end else begin
              phase_next = PH_UNFRAMED;
            end
          end
        end
        PH_LENGTH: begin
          valid                = 1'b1;
          bytes_remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = PH_DONE;
            done       = 1'b1;
          end
        end
        PH_CSIZE: begin
          if (data_byte == hrbd_pkg::CH_LF) begin
            size_digits_ended_next = 1'b0;
            if (bytes_remaining == '0) begin
              phase_next = PH_DONE;
              done       = 1'b1;
            end else begin
              phase_next = PH_CDATA;
            end
          end else if (!size_digits_ended) begin
            if (hex[4]) begin
              bytes_remaining_next = (size_wide[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0)
                                   ? {COUNT_WIDTH{1'b1}} : size_wide[COUNT_WIDTH-1:0];
            end else begin
              size_digits_ended_next = 1'b1;
            end
          end
        end
        PH_CDATA: begin
          valid                = 1'b1;
          bytes_remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = PH_CEND;
          end
        end
        PH_CEND: begin
          if (data_byte == hrbd_pkg::CH_LF) begin
            phase_next             = PH_CSIZE;
            bytes_remaining_next   = '0;
            size_digits_ended_next = 1'b0;
          end
        end
        PH_UNFRAMED: valid = 1'b1;
        default: valid = 1'b0;
      endcase
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      bytes_remaining   <= '0;
      size_digits_ended <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      bytes_remaining   <= bytes_remaining_next;
      size_digits_ended <= size_digits_ended_next;
    end
  end

  // Result flags follow the phase after this item.
  always_comb begin
    flags.body_valid    = valid;
    flags.response_done = done;
    flags.header_done   = (phase_next != PH_HEADER) && (phase_next != PH_CLOSED_HDR);
  end

endmodule
